FILE: hw/rtl/tsjb_pkg.sv
`default_nettype none
package tsjb_pkg;

  // Buffer geometry
  localparam int CAPACITY   = 65536;
  localparam int BYTE_AW    = 16;
  localparam int MAX_BLOCKS = 1024;
  localparam int BLK_AW     = 10;
  localparam int BCNT_W     = 11;
  localparam int LVL_W      = 17;
  localparam int MAX_READ   = 64;
  localparam int RLEN_W     = 7;
  localparam int BLEN_W     = 20;
  localparam int TS_PACKET  = 188;
  localparam int KEEP_MAX   = CAPACITY - (CAPACITY % TS_PACKET);
  localparam int CFG_IDX_W  = 2;

  // Operation codes
  localparam logic [3:0] OP_OPEN     = 4'd0;
  localparam logic [3:0] OP_READ     = 4'd1;
  localparam logic [3:0] OP_SUB_START = 4'd2;
  localparam logic [3:0] OP_SUB_BYTE = 4'd3;
  localparam logic [3:0] OP_SET_ACT  = 4'd4;
  localparam logic [3:0] OP_RESTART  = 4'd5;
  localparam logic [3:0] OP_FEC_RST  = 4'd6;
  localparam logic [3:0] OP_END      = 4'd7;
  localparam logic [3:0] OP_RETUNE   = 4'd8;
  localparam logic [3:0] OP_SHUTDOWN = 4'd9;
  localparam logic [3:0] OP_SNAPSHOT = 4'd10;

  // Actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_LOAD = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESUME_MARK = 2'd1;

  // Snapshot items
  localparam logic [3:0] ST_ACTIVE  = 4'd0;
  localparam logic [3:0] ST_BUFFER  = 4'd1;
  localparam logic [3:0] ST_QUEUED  = 4'd2;
  localparam logic [3:0] ST_CAP     = 4'd3;
  localparam logic [3:0] ST_LAST    = 4'd10;

  // Counter slots
  localparam int C_BLK_ACC   = 0;
  localparam int C_BYTE_ACC  = 1;
  localparam int C_BLK_PROC  = 2;
  localparam int C_BYTE_PROC = 3;
  localparam int C_DROP_BLK  = 4;
  localparam int C_DROP_BYTE = 5;
  localparam int C_DISCONT   = 6;
  localparam int NCNT        = 7;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [1:0]  action;
    logic [15:0] gen_out;
    logic [3:0]  stat_id;
    logic [63:0] stat_value;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tsjb_if.sv
`default_nettype none
// Input item channel
interface tsjb_item_if;
  logic                             valid;
  logic                             ready;
  logic [3:0]                       opcode;
  logic [7:0]                       in_byte;
  logic [tsjb_pkg::BLEN_W-1:0]      block_len;
  logic [tsjb_pkg::RLEN_W-1:0]      read_len;
  logic [15:0]                      reader_tag;
  logic                             reader_cancel;
  logic                             active_flag;
  modport source (output valid, opcode, in_byte, block_len, read_len, reader_tag,
                  reader_cancel, active_flag, input ready);
  modport sink (input valid, opcode, in_byte, block_len, read_len, reader_tag,
                reader_cancel, active_flag, output ready);
endinterface

// Result channel
interface tsjb_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [1:0]  action;
  logic [15:0] gen_out;
  logic [3:0]  stat_id;
  logic [63:0] stat_value;
  modport source (output valid, out_byte, byte_valid, last, action, gen_out, stat_id,
                  stat_value, input ready);
  modport sink (input valid, out_byte, byte_valid, last, action, gen_out, stat_id,
                stat_value, output ready);
endinterface

// Configuration write channel
interface tsjb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tsjb_pkg::CFG_IDX_W-1:0] index;
  logic [tsjb_pkg::LVL_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ts_playback_jitter_buffer_core.sv
`default_nettype none
// Channel  | Dir | Transfer when       | Payload
// item     | in  | valid && ready      | opcode, in_byte, block_len, read_len, tag, cancel, flag
// result   | out | valid && ready      | out_byte, byte_valid, last, action, gen_out, stat_*
// cfg      | in  | valid && ready      | index, data (ready always high)
//
// One item at a time: S_IDLE takes an item and S_EXEC runs it. A read then alternates S_RD_EMIT
// and S_RD_WAIT per delivered byte (byte ring and length ring read latency), submit start loops
// S_DROP_CHK/S_DROP_DO per dropped block, snapshot steps S_SNAP. Result stalls hold the engine.
// Synchronous reset clears control and counters; rings are not cleared.
module ts_playback_jitter_buffer_core (
  input  wire logic         clk,
  input  wire logic         rst,
  tsjb_item_if.sink         item,
  tsjb_result_if.source     result,
  tsjb_cfg_if.sink          cfg
);
  import tsjb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RD_EMIT, S_RD_WAIT, S_DROP_CHK, S_DROP_DO, S_SNAP
  } state_t;

  state_t state;

  // Captured item
  logic [3:0]        op_q;
  logic [7:0]        byte_q;
  logic [BLEN_W-1:0] blen_q;
  logic [RLEN_W-1:0] rlen_q;
  logic [15:0]       tag_q;
  logic              cancel_q;
  logic              flag_q;

  // Buffer state
  logic [BLK_AW-1:0]  block_head;
  logic [BCNT_W-1:0]  block_count;
  logic [BYTE_AW-1:0] byte_head;
  logic [LVL_W-1:0]   front_pos;
  logic [LVL_W-1:0]   queued;
  logic [15:0]        generation;
  logic               src_active, ended, buffering;
  logic               pend_valid;
  logic [BLEN_W-1:0]  pend_len, pend_got, pend_skip;
  logic [LVL_W-1:0]   pend_keep;
  logic [63:0]        stat_cnt [NCNT];
  logic [LVL_W-1:0]   low_mark, resume_mark;

  // Read engine
  logic [RLEN_W-1:0]  rd_n;
  logic [3:0]         snap_k;

  // Result register
  logic out_valid;
  res_t res_q;
  res_t res_next;
  logic emit;

  // Memories
  logic [7:0]       byte_mem [CAPACITY];
  logic [LVL_W-1:0] len_mem  [MAX_BLOCKS];
  logic [7:0]       byte_rd;
  logic [LVL_W-1:0] len_rd;
  logic             bw_en, lw_en;
  logic [BYTE_AW-1:0] bw_addr;
  logic [BLK_AW-1:0]  lw_addr;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  assign result.valid      = out_valid;
  assign result.out_byte   = res_q.out_byte;
  assign result.byte_valid = res_q.byte_valid;
  assign result.last       = res_q.last;
  assign result.action     = res_q.action;
  assign result.gen_out    = res_q.gen_out;
  assign result.stat_id    = res_q.stat_id;
  assign result.stat_value = res_q.stat_value;

  // Decode of the current item
  logic              can_emit, exec_go;
  logic              do_restart, do_shutdown, do_clear, new_active;
  logic [RLEN_W-1:0] rlen_sat;
  logic              rd_ok, sub_ok, byte_ok, blk_done;
  logic              drop_need;
  logic [LVL_W-1:0]  keep_len, rest_len;
  logic              fin, rd_last;
  logic [LVL_W-1:0]  queued_dec;
  logic [LVL_W-1:0]  queued_add;
  logic [2:0]        cnt_sel;

  always_comb begin
    can_emit = !out_valid || result.ready;
    exec_go  = (state == S_EXEC) && can_emit;
    new_active = (op_q == OP_SET_ACT) ? flag_q : src_active;
    do_restart = exec_go && ((op_q == OP_RESTART) || (op_q == OP_RETUNE) ||
                 ((op_q == OP_SET_ACT) && (src_active != flag_q) && (flag_q || !ended)));
    do_shutdown = exec_go && (op_q == OP_SHUTDOWN);
    do_clear = do_restart || do_shutdown;
    rlen_sat = (rlen_q > RLEN_W'(MAX_READ)) ? RLEN_W'(MAX_READ) : rlen_q;
    rd_ok = (rlen_sat != '0) && !cancel_q && (tag_q == generation) &&
            (src_active || ended) && (block_count != '0) && (ended || !buffering);
    sub_ok = (blen_q != '0) && src_active && !ended;
    byte_ok = pend_valid && src_active && !ended;
    blk_done = (pend_got + BLEN_W'(1)) >= pend_len;
    drop_need = (block_count != '0) &&
                (((21'(queued) + 21'(blen_q)) > 21'(CAPACITY)) ||
                 (block_count >= BCNT_W'(MAX_BLOCKS)));
    keep_len = (blen_q > BLEN_W'(CAPACITY)) ? LVL_W'(KEEP_MAX) : blen_q[LVL_W-1:0];
    rest_len = len_rd - front_pos;
    fin = (front_pos + LVL_W'(1)) >= len_rd;
    rd_last = ((rd_n + RLEN_W'(1)) == rlen_sat) || (fin && (block_count == BCNT_W'(1)));
    queued_dec = queued - LVL_W'(1);
    queued_add = queued + pend_keep;
    cnt_sel = 3'(snap_k - 4'd4);
    // Ring writes
    bw_en   = exec_go && (op_q == OP_SUB_BYTE) && byte_ok && (pend_got >= pend_skip);
    bw_addr = byte_head + queued[BYTE_AW-1:0] + BYTE_AW'(pend_got - pend_skip);
    lw_en   = exec_go && (op_q == OP_SUB_BYTE) && byte_ok && blk_done;
    lw_addr = block_head + block_count[BLK_AW-1:0];
  end

  // Next result and its load strobe
  always_comb begin
    emit     = 1'b0;
    res_next = '0;
    case (state)
      S_EXEC: begin
        if (can_emit) begin
          case (op_q)
            OP_OPEN: begin
              emit             = 1'b1;
              res_next.last    = 1'b1;
              res_next.gen_out = generation;
            end
            OP_READ: begin
              if (!rd_ok) begin
                emit          = 1'b1;
                res_next.last = 1'b1;
              end
            end
            OP_SET_ACT, OP_RESTART, OP_RETUNE: begin
              emit          = 1'b1;
              res_next.last = 1'b1;
              if (do_restart) begin
                res_next.action = new_active ? ACT_LOAD : ACT_STOP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD_EMIT: begin
        if (can_emit) begin
          emit                = 1'b1;
          res_next.out_byte   = byte_rd;
          res_next.byte_valid = 1'b1;
          res_next.last       = rd_last;
        end
      end
      S_SNAP: begin
        if (can_emit) begin
          emit             = 1'b1;
          res_next.stat_id = snap_k;
          res_next.last    = (snap_k == ST_LAST);
          case (snap_k)
            ST_ACTIVE: res_next.stat_value = 64'(src_active);
            ST_BUFFER: res_next.stat_value = 64'(src_active && buffering);
            ST_QUEUED: res_next.stat_value = 64'(queued);
            ST_CAP:    res_next.stat_value = 64'(CAPACITY);
            default:   res_next.stat_value = stat_cnt[cnt_sel];
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Byte ring, read address follows the read position
  always_ff @(posedge clk) begin
    if (bw_en) begin
      byte_mem[bw_addr] <= byte_q;
    end
    byte_rd <= byte_mem[byte_head];
  end

  // Length ring, read address follows the oldest block
  always_ff @(posedge clk) begin
    if (lw_en) begin
      len_mem[lw_addr] <= pend_keep;
    end
    len_rd <= len_mem[block_head];
  end

  // Control, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      block_head  <= '0;
      block_count <= '0;
      byte_head   <= '0;
      front_pos   <= '0;
      queued      <= '0;
      generation  <= '0;
      src_active  <= 1'b0;
      ended       <= 1'b0;
      buffering   <= 1'b1;
      pend_valid  <= 1'b0;
      low_mark    <= LVL_W'(16384);
      resume_mark <= LVL_W'(32768);
      for (int i = 0; i < NCNT; i++) begin
        stat_cnt[i] <= '0;
      end
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        res_q     <= res_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg.valid) begin
        if (cfg.index == REG_LOW_MARK) begin
          low_mark <= cfg.data;
        end else if (cfg.index == REG_RESUME_MARK) begin
          resume_mark <= cfg.data;
        end
      end

      case (state)
        S_IDLE: begin
          if (item.valid) begin
            op_q     <= item.opcode;
            byte_q   <= item.in_byte;
            blen_q   <= item.block_len;
            rlen_q   <= item.read_len;
            tag_q    <= item.reader_tag;
            cancel_q <= item.reader_cancel;
            flag_q   <= item.active_flag;
            state    <= S_EXEC;
          end
        end

        S_EXEC: begin
          if (can_emit) begin
            // Follow-on state by operation
            if ((op_q == OP_READ) && rd_ok) begin
              state <= S_RD_EMIT;
            end else if ((op_q == OP_SUB_START) && sub_ok) begin
              state <= S_DROP_CHK;
            end else if (op_q == OP_SNAPSHOT) begin
              state <= S_SNAP;
            end else begin
              state <= S_IDLE;
            end
            case (op_q)
              OP_READ: begin
                rd_n <= '0;
              end
              OP_SUB_START: begin
                if (sub_ok) begin
                  pend_valid <= 1'b0;
                end
              end
              OP_SUB_BYTE: begin
                if (byte_ok) begin
                  pend_got <= pend_got + BLEN_W'(1);
                  if (blk_done) begin
                    block_count <= block_count + BCNT_W'(1);
                    stat_cnt[C_BLK_ACC]  <= stat_cnt[C_BLK_ACC] + 64'd1;
                    stat_cnt[C_BYTE_ACC] <= stat_cnt[C_BYTE_ACC] + 64'(pend_keep);
                    queued     <= queued_add;
                    pend_valid <= 1'b0;
                    if (buffering && (queued_add >= resume_mark)) begin
                      buffering <= 1'b0;
                    end
                  end
                end
              end
              OP_SET_ACT, OP_RESTART, OP_RETUNE: begin
                if (op_q == OP_SET_ACT) begin
                  src_active <= flag_q;
                end
                if (op_q == OP_RETUNE) begin
                  stat_cnt[C_DISCONT] <= stat_cnt[C_DISCONT] + 64'd1;
                end
                if (do_restart) begin
                  ended <= 1'b0;
                end
              end
              OP_FEC_RST: begin
                stat_cnt[C_DISCONT] <= stat_cnt[C_DISCONT] + 64'd1;
              end
              OP_END: begin
                stat_cnt[C_DISCONT] <= stat_cnt[C_DISCONT] + 64'd1;
                ended     <= 1'b1;
                buffering <= 1'b0;
              end
              OP_SHUTDOWN: begin
                src_active <= 1'b0;
                ended      <= 1'b0;
              end
              OP_SNAPSHOT: begin
                snap_k <= '0;
              end
              default: begin
              end
            endcase

            // Buffer clear shared by restart, retune, set active and shutdown
            if (do_clear) begin
              generation  <= generation + 16'd1;
              stat_cnt[C_DROP_BLK]  <= stat_cnt[C_DROP_BLK] + 64'(block_count);
              stat_cnt[C_DROP_BYTE] <= stat_cnt[C_DROP_BYTE] + 64'(queued);
              block_count <= '0;
              front_pos   <= '0;
              queued      <= '0;
              buffering   <= 1'b1;
              pend_valid  <= 1'b0;
            end
          end
        end

        // One byte per visit; ring data is valid since the heads were stable
        S_RD_EMIT: begin
          if (can_emit) begin
            rd_n      <= rd_n + RLEN_W'(1);
            byte_head <= byte_head + BYTE_AW'(1);
            queued    <= queued_dec;
            stat_cnt[C_BYTE_PROC] <= stat_cnt[C_BYTE_PROC] + 64'd1;
            if (fin) begin
              block_head  <= block_head + BLK_AW'(1);
              block_count <= block_count - BCNT_W'(1);
              front_pos   <= '0;
              stat_cnt[C_BLK_PROC] <= stat_cnt[C_BLK_PROC] + 64'd1;
            end else begin
              front_pos <= front_pos + LVL_W'(1);
            end
            if (rd_last) begin
              state <= S_IDLE;
              if (!ended && (queued_dec <= low_mark)) begin
                buffering <= 1'b1;
              end
            end else begin
              state <= S_RD_WAIT;
            end
          end
        end

        // Ring read at the new heads
        S_RD_WAIT: begin
          state <= S_RD_EMIT;
        end

        // Make room for the announced block
        S_DROP_CHK: begin
          if (drop_need) begin
            state <= S_DROP_DO;
          end else begin
            if (keep_len != blen_q[LVL_W-1:0] || blen_q > BLEN_W'(CAPACITY)) begin
              stat_cnt[C_DROP_BLK]  <= stat_cnt[C_DROP_BLK] + 64'd1;
              stat_cnt[C_DROP_BYTE] <= stat_cnt[C_DROP_BYTE] +
                                       64'(blen_q - BLEN_W'(keep_len));
            end
            pend_valid <= 1'b1;
            pend_len   <= blen_q;
            pend_got   <= '0;
            pend_keep  <= keep_len;
            pend_skip  <= blen_q - BLEN_W'(keep_len);
            state      <= S_IDLE;
          end
        end

        S_DROP_DO: begin
          stat_cnt[C_DROP_BLK]  <= stat_cnt[C_DROP_BLK] + 64'd1;
          stat_cnt[C_DROP_BYTE] <= stat_cnt[C_DROP_BYTE] + 64'(rest_len);
          queued      <= queued - rest_len;
          byte_head   <= byte_head + rest_len[BYTE_AW-1:0];
          block_head  <= block_head + BLK_AW'(1);
          block_count <= block_count - BCNT_W'(1);
          front_pos   <= '0;
          state       <= S_DROP_CHK;
        end

        S_SNAP: begin
          if (can_emit) begin
            snap_k <= snap_k + 4'd1;
            if (snap_k == ST_LAST) begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tsjb_checker.sv
`default_nettype none
module tsjb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_valid,
  input wire logic       item_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       res_byte_valid,
  input wire logic       res_last,
  input wire logic [1:0] res_action,
  input wire logic [3:0] res_stat_id
);
  import tsjb_pkg::*;

  // A pending result stays offered until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before transfer");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while another is in work");

  // Data bytes carry no action or snapshot id
  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_byte_valid |-> (res_action == ACT_NONE) && (res_stat_id == ST_ACTIVE))
    else $error("byte result with stray fields");

  // Only the final snapshot item closes a snapshot; non-final non-byte is a snapshot item
  a_snap_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last && !res_byte_valid |-> (res_stat_id != ST_LAST))
    else $error("snapshot framing broken");

  // Action code stays in range
  a_action: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_action != 2'd3))
    else $error("bad action code");

endmodule

bind ts_playback_jitter_buffer_core tsjb_checker u_tsjb_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .res_byte_valid (result.byte_valid),
  .res_last       (result.last),
  .res_action     (result.action),
  .res_stat_id    (result.stat_id)
);
`default_nettype wire
